@@ rtl/dmxpwm_pkg.sv @@
// Shared types and constants for the lighting packet to PWM frame unit.
// Holds the gamma-2.6 table builder and the controller/datapath command types.
// No dependencies.
package dmxpwm_pkg;

  localparam int CHANNELS_DEF = 24;
  localparam int OFFSET_W     = 10;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd125;
  localparam int POS_W        = 11;
  localparam int PWM_W        = 12;
  localparam int PWM_MAX      = 4095;
  localparam int NBITS_W      = 5;

  typedef logic [255:0][PWM_W-1:0] gamma_tab_t;

  // Entry i = round(4095 * (i/255)^2.6), ties up, done exactly:
  // the count of k >= 0 with (2k+1)^5 * 255^13 <= 8190^5 * i^13.
  function automatic gamma_tab_t build_gamma();
    logic [175:0] base;
    logic [175:0] rhs;
    logic [175:0] prod;
    gamma_tab_t   tab;
    int           cnt;
    int           i;
    int           j;
    bit           stop;
    base = 176'd1;
    for (j = 0; j < 13; j++) base = base * 176'd255;
    cnt = 0;
    tab = '0;
    for (i = 0; i < 256; i++) begin
      rhs = 176'd1;
      for (j = 0; j < 13; j++) rhs = rhs * 176'(i);
      for (j = 0; j < 5; j++) rhs = rhs * 176'd8190;
      stop = 1'b0;
      while (cnt < PWM_MAX && !stop) begin
        prod = base;
        for (j = 0; j < 5; j++) prod = prod * 176'(2 * cnt + 1);
        if (prod > rhs) stop = 1'b1;
        else cnt++;
      end
      tab[i] = cnt[PWM_W-1:0];
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA = build_gamma();

  typedef struct packed {
    logic accept_en;
    logic ld_ch;
    logic dec_ch;
    logic load_acc;
    logic emit;
    logic flush;
  } dmxpwm_cmd_t;

  typedef struct packed {
    logic frame_go;
    logic nbits_ge8;
    logic nbits_zero;
    logic ch_zero;
    logic out_free;
  } dmxpwm_status_t;

endpackage

@@ rtl/dmxpwm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmxpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/dmxpwm_ctrl.sv @@
// Frame sequencer: takes packet bytes while idle, then walks channels from last
// to first issuing read / load / emit commands. Depends on dmxpwm_pkg.
module dmxpwm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dmxpwm_pkg::dmxpwm_status_t status,
  output dmxpwm_pkg::dmxpwm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (status.frame_go) begin
          cmd.ld_ch = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.load_acc = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (status.nbits_ge8) begin
          cmd.emit = status.out_free;
        end else if (!status.ch_zero) begin
          cmd.dec_ch = 1'b1;
          state_nxt  = S_RD;
        end else if (status.nbits_zero) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          // odd channel count: pad the final nibble
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_go_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && status.frame_go) |=> (state_r == S_RD))
    else $error("frame start did not enter channel read");

  a_no_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.flush) |-> status.out_free)
    else $error("byte emitted into a full output register");

  a_no_input_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD || state_r == S_RD) |-> !cmd.accept_en)
    else $error("input taken during frame generation");

endmodule

@@ rtl/dmxpwm_dp.sv @@
// Datapath: byte position tracking, start code and channel store, gamma lookup,
// 12-bit to byte packing and output register. Depends on dmxpwm_pkg, dmxpwm_ram.
module dmxpwm_dp #(
  parameter int CHANNELS = dmxpwm_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dmxpwm_pkg::dmxpwm_cmd_t             cmd,
  output dmxpwm_pkg::dmxpwm_status_t          status,
  input  logic                                cfg_we,
  input  logic [dmxpwm_pkg::OFFSET_W-1:0]     cfg_offset,
  input  logic                                in_valid,
  input  logic [7:0]                          in_byte,
  input  logic                                in_end,
  output logic                                in_ready,
  output logic                                out_valid,
  output logic [7:0]                          out_byte,
  output logic                                out_last,
  input  logic                                out_ready
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W = dmxpwm_pkg::POS_W;
  localparam int OFF_W = dmxpwm_pkg::OFFSET_W;
  localparam int NB_W  = dmxpwm_pkg::NBITS_W;
  localparam int PWM_W = dmxpwm_pkg::PWM_W;

  logic [OFF_W-1:0]  off_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  len_r;
  logic [7:0]        sc_r, sc_nxt;
  logic [CH_W-1:0]   ch_r;
  logic [15:0]       acc_r;
  logic [NB_W-1:0]   nbits_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic              accept;
  logic              pos_eq, pos_gt, idx_ok;
  logic [POS_W-1:0]  pos_inc, diff;
  logic              frame_go;
  logic [7:0]        rd_data;
  logic              reached;
  logic [PWM_W-1:0]  pwm_val;
  logic [NB_W-1:0]   nbits_left;
  logic [7:0]        emit_byte;

  assign in_ready = cmd.accept_en;
  assign accept   = in_valid && cmd.accept_en;

  assign pos_eq  = (pos_r == POS_W'(off_r));
  assign pos_gt  = (pos_r > POS_W'(off_r));
  assign diff    = pos_r - POS_W'(off_r) - POS_W'(1);
  assign idx_ok  = pos_gt && (diff < POS_W'(CHANNELS));
  assign pos_inc = (&pos_r) ? pos_r : pos_r + POS_W'(1);
  assign sc_nxt  = pos_eq ? in_byte : sc_r;
  assign frame_go = accept && in_end && (pos_inc > POS_W'(off_r)) && (sc_nxt == 8'h00);
  assign pos_nxt = in_end ? '0 : pos_inc;

  dmxpwm_ram #(
    .WIDTH (8),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk     (clk),
    .wr_en   (accept && idx_ok),
    .wr_addr (diff[CH_W-1:0]),
    .wr_data (in_byte),
    .rd_addr (ch_r),
    .rd_data (rd_data)
  );

  // channel reached if offset + 1 + ch < packet length
  assign reached = ((POS_W+1)'(off_r) + (POS_W+1)'(1) + (POS_W+1)'(ch_r))
                   < (POS_W+1)'(len_r);
  assign pwm_val = reached ? dmxpwm_pkg::GAMMA[rd_data] : '0;

  assign nbits_left = nbits_r - NB_W'(8);
  always_comb begin
    case (nbits_r)
      NB_W'(16): emit_byte = acc_r[15:8];
      NB_W'(12): emit_byte = acc_r[11:4];
      default:   emit_byte = acc_r[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= dmxpwm_pkg::OFFSET_RESET;
      pos_r       <= '0;
      sc_r        <= '0;
      nbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        off_r <= cfg_offset;
      end
      if (accept) begin
        pos_r <= pos_nxt;
        sc_r  <= sc_nxt;
      end
      if (cmd.load_acc) begin
        nbits_r <= nbits_r + NB_W'(PWM_W);
      end else if (cmd.emit) begin
        nbits_r <= nbits_left;
      end else if (cmd.flush) begin
        nbits_r <= '0;
      end
      if (cmd.emit || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_go) begin
      len_r <= pos_inc;
    end
    if (cmd.ld_ch) begin
      ch_r <= CH_W'(CHANNELS - 1);
    end else if (cmd.dec_ch) begin
      ch_r <= ch_r - CH_W'(1);
    end
    // acc holds at most 4 pending bits before a load
    if (cmd.load_acc) begin
      acc_r <= {acc_r[3:0], pwm_val};
    end else if (cmd.emit) begin
      acc_r <= acc_r & ~(16'hFFFF << nbits_left);
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= (ch_r == '0) && (nbits_r == NB_W'(8));
    end else if (cmd.flush) begin
      out_byte_r <= {acc_r[3:0], 4'h0};
      out_last_r <= 1'b1;
    end
  end

  assign status.frame_go   = frame_go;
  assign status.nbits_ge8  = (nbits_r >= NB_W'(8));
  assign status.nbits_zero = (nbits_r == '0);
  assign status.ch_zero    = (ch_r == '0);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_nbits_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (nbits_r[1:0] == 2'b00) && (nbits_r <= NB_W'(16)))
    else $error("bit accumulator count out of range");

  a_load_low_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_acc |-> (nbits_r < NB_W'(8)))
    else $error("channel loaded while a full byte was pending");

  a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end) |=> (pos_r == '0))
    else $error("byte position not cleared after packet end");

endmodule

@@ rtl/dmx_packet_to_pwm_frame_unit.sv @@
// Lighting packet to 12-bit PWM shift frame: top level.
// Depends on dmxpwm_pkg, dmxpwm_ctrl, dmxpwm_dp, dmxpwm_ram.
//
// Payload bytes are taken one per cycle while the unit is idle. The byte at
// data_offset is the start code and the next CHANNELS bytes are channel levels.
// On the beat flagged by in_tlast the packet is checked (it must reach past the
// offset with a zero start code); a good packet produces ceil(12*CHANNELS/8)
// frame bytes, last channel first, MSB first, each level passed through a
// gamma-2.6 12-bit table; channels the packet did not reach send zero. The
// final frame byte carries out_tlast. While a frame is built in_tready is low:
// each channel costs a RAM read, a table load, one or two byte beats and a step
// to the next channel, and a stalled output holds the frame. Bad packets produce
// nothing and the unit is ready again next cycle.
module dmx_packet_to_pwm_frame_unit #(
  parameter int CHANNELS = dmxpwm_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,     // [9:0] data_offset, upper bits unused
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] payload_byte
  input  logic        in_tlast,     // packet_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] frame_byte
  output logic        out_tlast     // frame_last
);

  dmxpwm_pkg::dmxpwm_cmd_t    cmd;
  dmxpwm_pkg::dmxpwm_status_t status;

  assign cfg_ready = 1'b1;

  dmxpwm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  dmxpwm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid),
    .cfg_offset (cfg_data[dmxpwm_pkg::OFFSET_W-1:0]),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_end     (in_tlast),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

endmodule
